@@ rtl/core/bti_pkg.sv @@
// Shared constants for the barycentric triangle interpolator.
`default_nettype none
package bti_pkg;
    // register stages in the geometry and weight sections
    localparam int unsigned GEOM_STAGES   = 3;
    localparam int unsigned WEIGHT_STAGES = 3;
endpackage
`default_nettype wire

@@ rtl/core/bti_geom.sv @@
// Edge vectors, cross-product terms and the determinant and weight numerators.
`default_nettype none
module bti_geom #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COORD_BITS-1:0]      a_x,
    input  wire logic signed [COORD_BITS-1:0]      a_y,
    input  wire logic signed [COORD_BITS-1:0]      b_x,
    input  wire logic signed [COORD_BITS-1:0]      b_y,
    input  wire logic signed [COORD_BITS-1:0]      c_x,
    input  wire logic signed [COORD_BITS-1:0]      c_y,
    input  wire logic signed [COORD_BITS-1:0]      q_x,
    input  wire logic signed [COORD_BITS-1:0]      q_y,
    input  wire logic signed [VALUE_BITS-1:0]      a_value,
    input  wire logic signed [VALUE_BITS-1:0]      b_value,
    input  wire logic signed [VALUE_BITS-1:0]      c_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [2*COORD_BITS+1:0]         det,
    output logic signed [2*COORD_BITS+1:0]         num_c,
    output logic signed [2*COORD_BITS+1:0]         num_b,
    output logic signed [VALUE_BITS-1:0]           va,
    output logic signed [VALUE_BITS-1:0]           vb,
    output logic signed [VALUE_BITS-1:0]           vc
);
    import bti_pkg::*;

    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned KW = 2 * DW;

    logic [GEOM_STAGES-1:0] v_reg;
    logic [GEOM_STAGES:0]   ld;

    logic signed [DW-1:0] v0x_reg, v0y_reg, v1x_reg, v1y_reg, v2x_reg, v2y_reg;
    logic signed [KW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [KW-1:0] k_reg, nc_reg, nb_reg;
    logic signed [VALUE_BITS-1:0] va1_reg, vb1_reg, vc1_reg;
    logic signed [VALUE_BITS-1:0] va2_reg, vb2_reg, vc2_reg;
    logic signed [VALUE_BITS-1:0] va3_reg, vb3_reg, vc3_reg;

    // elastic ready chain: a stage loads when empty or when it drains
    always_comb
    begin
        ld[GEOM_STAGES] = out_ready;
        for (int i = GEOM_STAGES - 1; i >= 0; i--)
        begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end
    assign in_ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0]) v_reg[0] <= in_valid;
            if (ld[1]) v_reg[1] <= v_reg[0];
            if (ld[2]) v_reg[2] <= v_reg[1];
        end
    end

    // stage 1: edge vectors
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            v0x_reg <= DW'(c_x) - DW'(a_x);
            v0y_reg <= DW'(c_y) - DW'(a_y);
            v1x_reg <= DW'(b_x) - DW'(a_x);
            v1y_reg <= DW'(b_y) - DW'(a_y);
            v2x_reg <= DW'(q_x) - DW'(a_x);
            v2y_reg <= DW'(q_y) - DW'(a_y);
            va1_reg <= a_value;
            vb1_reg <= b_value;
            vc1_reg <= c_value;
        end
    end

    // stage 2: six cross-product terms
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            p0_reg  <= v0x_reg * v1y_reg;
            p1_reg  <= v0y_reg * v1x_reg;
            p2_reg  <= v2x_reg * v1y_reg;
            p3_reg  <= v2y_reg * v1x_reg;
            p4_reg  <= v0x_reg * v2y_reg;
            p5_reg  <= v0y_reg * v2x_reg;
            va2_reg <= va1_reg;
            vb2_reg <= vb1_reg;
            vc2_reg <= vc1_reg;
        end
    end

    // stage 3: determinant and numerators
    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            k_reg   <= p0_reg - p1_reg;
            nc_reg  <= p2_reg - p3_reg;
            nb_reg  <= p4_reg - p5_reg;
            va3_reg <= va2_reg;
            vb3_reg <= vb2_reg;
            vc3_reg <= vc2_reg;
        end
    end

    assign out_valid = v_reg[GEOM_STAGES-1];
    assign det   = k_reg;
    assign num_c = nc_reg;
    assign num_b = nb_reg;
    assign va    = va3_reg;
    assign vb    = vb3_reg;
    assign vc    = vc3_reg;
endmodule
`default_nettype wire

@@ rtl/core/bti_weight.sv @@
// Sign normalisation, inside test, weighted sum and rounded division operands.
`default_nettype none
module bti_weight #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [2*COORD_BITS+1:0]          det,
    input  wire logic signed [2*COORD_BITS+1:0]          num_c,
    input  wire logic signed [2*COORD_BITS+1:0]          num_b,
    input  wire logic signed [VALUE_BITS-1:0]            va,
    input  wire logic signed [VALUE_BITS-1:0]            vb,
    input  wire logic signed [VALUE_BITS-1:0]            vc,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [2*COORD_BITS+VALUE_BITS+2:0]           dividend,
    output logic [2*COORD_BITS+1:0]                      divisor,
    output logic signed [VALUE_BITS-1:0]                 vmin,
    output logic                                         in_tri
);
    import bti_pkg::*;

    localparam int unsigned KW   = 2 * COORD_BITS + 2;
    localparam int unsigned NW   = KW - 1;
    localparam int unsigned SW   = NW + VALUE_BITS;
    localparam int unsigned NUMW = SW + 2;

    logic [WEIGHT_STAGES-1:0] v_reg;
    logic [WEIGHT_STAGES:0]   ld;

    logic signed [KW-1:0] kk, ncc, nbb;
    logic signed [KW:0]   na;
    logic signed [VALUE_BITS-1:0] m;
    logic [NW-1:0] k4_reg, nc4_reg, nb4_reg, na4_reg, k5_reg;
    logic [VALUE_BITS-1:0] da_reg, db_reg, dc_reg;
    logic signed [VALUE_BITS-1:0] m4_reg, m5_reg, m6_reg;
    logic in4_reg, in5_reg, in6_reg;
    logic [SW-1:0] pa_reg, pb_reg, pc_reg;
    logic [SW-1:0] s;
    logic [NUMW-1:0] num6_reg;
    logic [NW:0] den6_reg;

    always_comb
    begin
        ld[WEIGHT_STAGES] = out_ready;
        for (int i = WEIGHT_STAGES - 1; i >= 0; i--)
        begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end
    assign in_ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0]) v_reg[0] <= in_valid;
            if (ld[1]) v_reg[1] <= v_reg[0];
            if (ld[2]) v_reg[2] <= v_reg[1];
        end
    end

    // make the determinant positive, then the third weight and the min value
    always_comb
    begin
        kk  = det[KW-1] ? -det   : det;
        ncc = det[KW-1] ? -num_c : num_c;
        nbb = det[KW-1] ? -num_b : num_b;
        na  = (KW+1)'(kk) - (KW+1)'(ncc) - (KW+1)'(nbb);
        m   = va;
        if (vb < m) m = vb;
        if (vc < m) m = vc;
    end

    // stage 4: magnitudes, inside flag, value offsets from the minimum
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            k4_reg  <= kk[NW-1:0];
            nc4_reg <= ncc[NW-1:0];
            nb4_reg <= nbb[NW-1:0];
            na4_reg <= na[NW-1:0];
            in4_reg <= (det != '0) && !ncc[KW-1] && !nbb[KW-1] && !na[KW];
            m4_reg  <= m;
            da_reg  <= VALUE_BITS'(va - m);
            db_reg  <= VALUE_BITS'(vb - m);
            dc_reg  <= VALUE_BITS'(vc - m);
        end
    end

    // stage 5: weight times value offset
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            pa_reg  <= SW'(na4_reg) * SW'(da_reg);
            pb_reg  <= SW'(nb4_reg) * SW'(db_reg);
            pc_reg  <= SW'(nc4_reg) * SW'(dc_reg);
            k5_reg  <= k4_reg;
            m5_reg  <= m4_reg;
            in5_reg <= in4_reg;
        end
    end

    // stage 6: round half up as (2S + k) / 2k
    assign s = pa_reg + pb_reg + pc_reg;
    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            num6_reg <= {1'b0, s, 1'b0} + NUMW'(k5_reg);
            den6_reg <= {k5_reg, 1'b0};
            m6_reg   <= m5_reg;
            in6_reg  <= in5_reg;
        end
    end

    assign out_valid = v_reg[WEIGHT_STAGES-1];
    assign dividend  = num6_reg;
    assign divisor   = den6_reg;
    assign vmin      = m6_reg;
    assign in_tri    = in6_reg;
endmodule
`default_nettype wire

@@ rtl/core/bti_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, and the result register.
`default_nettype none
module bti_div #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [2*COORD_BITS+VALUE_BITS+2:0]  dividend,
    input  wire logic [2*COORD_BITS+1:0]             divisor,
    input  wire logic signed [VALUE_BITS-1:0]        vmin,
    input  wire logic                                in_tri,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [VALUE_BITS-1:0]             interpolated,
    output logic                                     inside_res
);
    localparam int unsigned NUMW = 2 * COORD_BITS + VALUE_BITS + 3;
    localparam int unsigned DENW = 2 * COORD_BITS + 2;
    localparam int unsigned NS   = VALUE_BITS;

    logic [NS-1:0] v_reg;
    logic [NS:0]   ld;
    logic          ov_reg;

    logic [NUMW-1:0]             r_reg   [NS];
    logic [VALUE_BITS-1:0]       q_reg   [NS];
    logic [DENW-1:0]             d_reg   [NS];
    logic signed [VALUE_BITS-1:0] m_reg  [NS];
    logic [NS-1:0]               ins_reg;

    logic [NUMW-1:0]             r_src   [NS];
    logic [VALUE_BITS-1:0]       q_src   [NS];
    logic [DENW-1:0]             d_src   [NS];
    logic signed [VALUE_BITS-1:0] m_src  [NS];
    logic [NS-1:0]               ins_src;
    logic [NS-1:0]               v_src;

    logic signed [VALUE_BITS-1:0] res_reg;
    logic                         ins_out_reg;

    always_comb
    begin
        ld[NS] = !ov_reg || out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end
    assign in_ready = ld[0];

    // stage inputs: first from the port, the rest from the previous stage
    always_comb
    begin
        r_src[0]   = dividend;
        q_src[0]   = '0;
        d_src[0]   = divisor;
        m_src[0]   = vmin;
        ins_src[0] = in_tri;
        v_src[0]   = in_valid;
        for (int j = 1; j < NS; j++)
        begin
            r_src[j]   = r_reg[j-1];
            q_src[j]   = q_reg[j-1];
            d_src[j]   = d_reg[j-1];
            m_src[j]   = m_reg[j-1];
            ins_src[j] = ins_reg[j-1];
            v_src[j]   = v_reg[j-1];
        end
    end

    // one trial subtraction per stage, most significant quotient bit first
    for (genvar j = 0; j < NS; j++)
    begin : g_step
        logic [NUMW-1:0] den_sh;
        logic            ge;

        assign den_sh = NUMW'(d_src[j]) << (NS - 1 - j);
        assign ge     = r_src[j] >= den_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (ld[j])
            begin
                v_reg[j] <= v_src[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[j])
            begin
                r_reg[j]   <= ge ? r_src[j] - den_sh : r_src[j];
                q_reg[j]   <= q_src[j] | (VALUE_BITS'(ge) << (NS - 1 - j));
                d_reg[j]   <= d_src[j];
                m_reg[j]   <= m_src[j];
                ins_reg[j] <= ins_src[j];
            end
        end
    end

    // output register: add back the minimum, zero when outside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (ld[NS])
        begin
            ov_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[NS])
        begin
            res_reg     <= ins_reg[NS-1] ? m_reg[NS-1] + $signed(q_reg[NS-1]) : '0;
            ins_out_reg <= ins_reg[NS-1];
        end
    end

    assign out_valid    = ov_reg;
    assign interpolated = res_reg;
    assign inside_res   = ins_out_reg;

    // inside implies a nonzero divisor
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_tri) |-> (divisor != '0))
        else $error("inside item with zero divisor");

    // quotient must fit the value width for inside items
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_tri) |-> (dividend < ((NUMW+NS)'(divisor) << NS)))
        else $error("quotient overflows value width");

    // outside results are zero
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !ins_out_reg) |-> (res_reg == '0))
        else $error("outside item with nonzero value");
endmodule
`default_nettype wire

@@ rtl/core/barycentric_triangle_interpolator.sv @@
// Barycentric triangle interpolator: stream ports and the pipeline sections.
//
// Slave channel s_*: one item per handshake, a triangle A, B, C, a query
// point Q and a value at each vertex. Master channel m_*: one result item
// per input item, in order: the blended value, rounded half up, and an
// inside flag in m_tuser (0 for a degenerate triangle or a point outside,
// with the value then 0).
// Pipeline: 3 geometry stages, 3 weight stages, VALUE_BITS divider stages
// and the output register.
// Throughput: one item per cycle while the receiver takes results; every
// stage has its own valid bit and loads when it is empty or its successor
// takes its contents, so bubbles close up under stall.
// Reset clears all valid bits; the pipeline then holds no items.
// When the receiver stalls, the result stays in the output register and
// earlier stages keep filling until the pipeline is full, after which
// s_tready falls; nothing is lost or repeated.
`default_nettype none
module barycentric_triangle_interpolator #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, q_x, q_y, a_value, b_value, c_value
    input  wire logic [((8*COORD_BITS+3*VALUE_BITS+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // interpolated
    output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata,
    // inside_res
    output logic      m_tuser
);
    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned VB = VALUE_BITS;
    localparam int unsigned KW = 2 * CB + 2;
    localparam int unsigned OW = ((VB + 7) / 8) * 8;

    logic g_valid, g_ready, w_valid, w_ready;
    logic signed [KW-1:0] det, num_c, num_b;
    logic signed [VB-1:0] va, vb, vc, vmin, interpolated;
    logic [2*CB+VB+2:0] dividend;
    logic [KW-1:0] divisor;
    logic in_tri;

    // geometry: edge vectors and cross products
    bti_geom #(.COORD_BITS(CB), .VALUE_BITS(VB)) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .a_x       (s_tdata[0*CB +: CB]),
        .a_y       (s_tdata[1*CB +: CB]),
        .b_x       (s_tdata[2*CB +: CB]),
        .b_y       (s_tdata[3*CB +: CB]),
        .c_x       (s_tdata[4*CB +: CB]),
        .c_y       (s_tdata[5*CB +: CB]),
        .q_x       (s_tdata[6*CB +: CB]),
        .q_y       (s_tdata[7*CB +: CB]),
        .a_value   (s_tdata[8*CB +: VB]),
        .b_value   (s_tdata[8*CB+VB +: VB]),
        .c_value   (s_tdata[8*CB+2*VB +: VB]),
        .out_valid (g_valid),
        .out_ready (g_ready),
        .det       (det),
        .num_c     (num_c),
        .num_b     (num_b),
        .va        (va),
        .vb        (vb),
        .vc        (vc)
    );

    // weights, inside test, division operands
    bti_weight #(.COORD_BITS(CB), .VALUE_BITS(VB)) u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_ready  (g_ready),
        .det       (det),
        .num_c     (num_c),
        .num_b     (num_b),
        .va        (va),
        .vb        (vb),
        .vc        (vc),
        .out_valid (w_valid),
        .out_ready (w_ready),
        .dividend  (dividend),
        .divisor   (divisor),
        .vmin      (vmin),
        .in_tri    (in_tri)
    );

    // divider and output register
    bti_div #(.COORD_BITS(CB), .VALUE_BITS(VB)) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (w_valid),
        .in_ready     (w_ready),
        .dividend     (dividend),
        .divisor      (divisor),
        .vmin         (vmin),
        .in_tri       (in_tri),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .interpolated (interpolated),
        .inside_res   (m_tuser)
    );

    assign m_tdata = OW'(unsigned'(interpolated));
endmodule
`default_nettype wire

@@ test/tb_bti_checker.sv @@
// Checker for the barycentric triangle interpolator: predicts each result and compares.
`timescale 1ns / 1ps
module tb_bti_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [175:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [15:0]  m_tdata,
    input  wire logic         m_tuser,
    output int                fail_count,
    output int                pending
);
    typedef struct packed {
        logic        in_tri;
        logic [15:0] value;
    } blend_t;

    blend_t blend_q[$];

    // exact blend of the vertex values at the query point
    function automatic blend_t blend_at(input logic [175:0] d);
        longint ax, ay, bx, by, cx, cy, qx, qy, va, vb, vc;
        longint k, nc, nb, na, lo_v;
        logic signed [127:0] acc, quo;
        blend_t r;
        ax = longint'($signed(d[15:0]));    ay = longint'($signed(d[31:16]));
        bx = longint'($signed(d[47:32]));   by = longint'($signed(d[63:48]));
        cx = longint'($signed(d[79:64]));   cy = longint'($signed(d[95:80]));
        qx = longint'($signed(d[111:96]));  qy = longint'($signed(d[127:112]));
        va = longint'($signed(d[143:128]));
        vb = longint'($signed(d[159:144]));
        vc = longint'($signed(d[175:160]));
        k  = (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
        nc = (qx - ax) * (by - ay) - (qy - ay) * (bx - ax);
        nb = (cx - ax) * (qy - ay) - (cy - ay) * (qx - ax);
        r = '0;
        if (k == 0)
            return r;
        if (k < 0)
        begin
            k = -k; nc = -nc; nb = -nb;
        end
        na = k - nc - nb;
        if (nc < 0 || nb < 0 || na < 0)
            return r;
        lo_v = va;
        if (vb < lo_v) lo_v = vb;
        if (vc < lo_v) lo_v = vc;
        acc = 128'(nc) * 128'(vc - lo_v) + 128'(nb) * 128'(vb - lo_v)
            + 128'(na) * 128'(va - lo_v);
        // round half up
        quo = (2 * acc + 128'(k)) / (2 * 128'(k));
        r.in_tri = 1'b1;
        r.value  = 16'(lo_v + longint'(quo));
        return r;
    endfunction

    assign pending = blend_q.size();

    always @(posedge clk)
    begin
        blend_t exp_r;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                blend_q.push_back(blend_at(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (blend_q.size() == 0)
                begin
                    $error("unexpected result item: interpolated %0d inside_res %0b",
                           $signed(m_tdata), m_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = blend_q.pop_front();
                    if (m_tuser !== exp_r.in_tri)
                    begin
                        $error("inside_res: expected %0b actual %0b", exp_r.in_tri, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                    else if (m_tdata !== exp_r.value)
                    begin
                        $error("interpolated: expected %0d actual %0d",
                               $signed(exp_r.value), $signed(m_tdata));
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

@@ test/tb_barycentric_triangle_interpolator.sv @@
// Testbench top: stimulus, idling and verdict for the barycentric triangle interpolator.
`timescale 1ns / 1ps
module tb_barycentric_triangle_interpolator;
    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic         m_tuser;
    int           fail_count;
    int           pending;
    logic [175:0] tri_q[$];

    always #2 clk = ~clk;

    barycentric_triangle_interpolator u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    tb_bti_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // pack one item, first field lowest
    function automatic logic [175:0] pack_tri(input int ax, ay, bx, by, cx, cy, qx, qy,
                                              input int va, vb, vc);
        return {16'(vc), 16'(vb), 16'(va), 16'(qy), 16'(qx), 16'(cy), 16'(cx),
                16'(by), 16'(bx), 16'(ay), 16'(ax)};
    endfunction

    function automatic int rnd16();
        return int'($signed(16'($urandom)));
    endfunction

    // coordinate near a centre, mostly small spread, sometimes full range
    function automatic int near(input int c, input int spread);
        int v;
        v = c + $urandom_range(2 * spread) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // receiver stall pattern
    always @(posedge clk)
    begin
        int ph;
        ph = $urandom_range(99);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (ph < 8)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(3) != 0) || ($time % 4000 < 800);
    end

    initial
    begin
        logic [175:0] item;
        int burst, ox, oy, sp, lo_b, hi_b;
        // directed: extremes, degenerate, edges, vertices, outside, ties
        tri_q.push_back(pack_tri(0, 0, 0, 10, 10, 0, 2, 2, 100, 200, 300));
        tri_q.push_back(pack_tri(0, 0, 10, 0, 0, 10, 2, 2, 100, 200, 300));
        tri_q.push_back(pack_tri(0, 0, 10, 0, 20, 0, 5, 0, 1, 2, 3));
        tri_q.push_back(pack_tri(5, 5, 5, 5, 5, 5, 5, 5, 7, 7, 7));
        tri_q.push_back(pack_tri(0, 0, 10, 0, 0, 10, 0, 0, -32768, 32767, 0));
        tri_q.push_back(pack_tri(0, 0, 10, 0, 0, 10, 10, 0, -32768, 32767, 0));
        tri_q.push_back(pack_tri(0, 0, 10, 0, 0, 10, 0, 10, -32768, 32767, 0));
        tri_q.push_back(pack_tri(0, 0, 10, 0, 0, 10, 5, 5, 1, 2, 3));
        tri_q.push_back(pack_tri(0, 0, 10, 0, 0, 10, 6, 5, 1, 2, 3));
        tri_q.push_back(pack_tri(0, 0, 10, 0, 0, 10, -1, 5, 1, 2, 3));
        tri_q.push_back(pack_tri(0, 0, 2, 0, 0, 2, 1, 0, 0, 1, 0));
        tri_q.push_back(pack_tri(0, 0, 2, 0, 0, 2, 1, 0, 0, -1, 0));
        tri_q.push_back(pack_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0,
                                 -32768, 32767, -32768));
        tri_q.push_back(pack_tri(32767, 32767, -32768, 32767, 32767, -32768, -1, -1,
                                 32767, -32768, 32767));
        tri_q.push_back(pack_tri(-32768, -32768, 32767, 32767, -32768, 32767, 32767,
                                 -32768, 1, 1, 1));
        tri_q.push_back(pack_tri(-32768, -32768, 32767, -32768, -32768, 32767, -32768,
                                 -32768, -1, -1, -1));
        tri_q.push_back(pack_tri(0, 0, 3, 0, 0, 3, 1, 1, 0, 1, 1));
        tri_q.push_back(pack_tri(0, 0, 3, 0, 0, 3, 1, 1, 0, -1, -1));
        // random: mostly points inside or near small triangles
        for (int i = 0; i < 950; i++)
        begin
            ox = rnd16(); oy = rnd16();
            sp = ($urandom_range(9) == 0) ? 32767 : ($urandom_range(1) ? 40 : 3000);
            if ($urandom_range(4) == 0)
                item = pack_tri(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                                rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
            else
            begin
                lo_b = ($urandom_range(3) == 0) ? 1 : 0;
                item = pack_tri(near(ox, sp), near(oy, sp), near(ox, sp), near(oy, sp),
                                near(ox, sp), near(oy, sp), near(ox, sp / 2 + lo_b),
                                near(oy, sp / 2 + lo_b), rnd16(), rnd16(), rnd16());
                // small value spread now and then for rounding ties
                if ($urandom_range(2) == 0)
                    item[175:128] = {16'(near(0, 3)), 16'(near(0, 3)), 16'(near(0, 3))};
            end
            tri_q.push_back(item);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender in bursts with gaps
        while (tri_q.size() > 0)
        begin
            burst = $urandom_range(1, 30);
            hi_b = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && tri_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= tri_q.pop_front();
                @(posedge clk);
                while (!s_tready) @(posedge clk);
                burst--;
            end
            if (hi_b > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= pack_tri(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                                     rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
                repeat (hi_b) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        while (pending > 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb_barycentric_triangle_interpolator OK");
        else
            $display("tb_barycentric_triangle_interpolator NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("tb_barycentric_triangle_interpolator NOT OK");
        $finish;
    end
endmodule

@@ barycentric_triangle_interpolator.f @@
rtl/core/bti_pkg.sv
rtl/core/bti_geom.sv
rtl/core/bti_weight.sv
rtl/core/bti_div.sv
rtl/core/barycentric_triangle_interpolator.sv
test/tb_bti_checker.sv
test/tb_barycentric_triangle_interpolator.sv
